// ----- design/lve_pkg.sv -----
// Package: shared types, substitution tables and codes for the leet variant enumerator.
package lve_pkg;

  localparam int MAX_WORD_LEN_DEF = 32;

  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_NEXT   = 2'd2;

  localparam logic [2:0] SET_ZERO   = 3'd0;
  localparam logic [2:0] SET_ONE    = 3'd1;
  localparam logic [2:0] SET_TWO    = 3'd2;
  localparam logic [2:0] SET_THREE  = 3'd3;
  localparam logic [2:0] SET_FOUR   = 3'd4;
  localparam logic [2:0] SET_DOLLAR = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV_RD,
    ST_ADV_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EXH
  } lve_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       flag;
    logic [2:0] set;
    logic [1:0] pos;
  } lve_entry_t;

  typedef struct packed {
    logic clear_word;
    logic append;
    logic idx_clear;
    logic idx_inc;
    logic adv_write;
    logic exh_sel;
  } lve_cmd_t;

  typedef struct packed {
    logic any_subst;
    logic at_last;
    logic rd_flag;
    logic rd_wrap;
  } lve_stat_t;

  function automatic logic [3:0] head_match(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h30:   r = {1'b1, SET_ZERO};
      8'h31:   r = {1'b1, SET_ONE};
      8'h32:   r = {1'b1, SET_TWO};
      8'h33:   r = {1'b1, SET_THREE};
      8'h34:   r = {1'b1, SET_FOUR};
      8'h24:   r = {1'b1, SET_DOLLAR};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] set_size(input logic [2:0] set);
    logic [2:0] r;
    case (set)
      SET_ZERO: r = 3'd3;
      SET_ONE:  r = 3'd4;
      SET_FOUR: r = 3'd3;
      default:  r = 3'd2;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] set_char(input logic [2:0] set, input logic [1:0] pos);
    logic [7:0] r;
    case ({set, pos})
      {SET_ZERO, 2'd0}:   r = 8'h30;
      {SET_ZERO, 2'd1}:   r = 8'h6f;
      {SET_ZERO, 2'd2}:   r = 8'h4f;
      {SET_ONE, 2'd0}:    r = 8'h31;
      {SET_ONE, 2'd1}:    r = 8'h69;
      {SET_ONE, 2'd2}:    r = 8'h6c;
      {SET_ONE, 2'd3}:    r = 8'h49;
      {SET_TWO, 2'd0}:    r = 8'h32;
      {SET_TWO, 2'd1}:    r = 8'h61;
      {SET_THREE, 2'd0}:  r = 8'h33;
      {SET_THREE, 2'd1}:  r = 8'h65;
      {SET_FOUR, 2'd0}:   r = 8'h34;
      {SET_FOUR, 2'd1}:   r = 8'h61;
      {SET_FOUR, 2'd2}:   r = 8'h68;
      {SET_DOLLAR, 2'd0}: r = 8'h24;
      {SET_DOLLAR, 2'd1}: r = 8'h73;
      default:            r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- design/lve_dp.sv -----
// Datapath: word memory, length, odometer index and result formatting.
module lve_dp #(
  parameter int MAX_WORD_LEN = lve_pkg::MAX_WORD_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lve_pkg::lve_cmd_t cmd,
  input  logic [7:0]        ch,
  output lve_pkg::lve_stat_t stat,
  output logic [7:0]        out_char,
  output logic              last,
  output logic              exhausted
);

  localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  lve_pkg::lve_entry_t mem [MAX_WORD_LEN];
  lve_pkg::lve_entry_t rd_data;
  lve_pkg::lve_entry_t wr_data;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic [LW-1:0]       len;
  logic                any_subst;
  logic [AW-1:0]       idx;
  logic [3:0]          hit;
  logic                can_append;
  logic [2:0]          pos_inc;
  logic                wrap;
  logic [7:0]          cur_char;

  assign hit        = lve_pkg::head_match(ch);
  assign can_append = cmd.append && (ch != 8'd0) && (len < LW'(MAX_WORD_LEN));
  assign pos_inc    = {1'b0, rd_data.pos} + 3'd1;
  assign wrap       = pos_inc >= lve_pkg::set_size(rd_data.set);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (can_append) begin
      wr_en        = 1'b1;
      wr_addr      = len[AW-1:0];
      wr_data.ch   = ch;
      wr_data.flag = hit[3];
      wr_data.set  = hit[2:0];
      wr_data.pos  = 2'd0;
    end else if (cmd.adv_write && rd_data.flag) begin
      wr_en       = 1'b1;
      wr_data.pos = wrap ? 2'd0 : pos_inc[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      any_subst <= 1'b0;
      idx       <= '0;
    end else begin
      if (cmd.clear_word) begin
        len       <= '0;
        any_subst <= 1'b0;
      end else if (can_append) begin
        len       <= len + LW'(1);
        any_subst <= any_subst | hit[3];
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
    end
  end

  assign cur_char = rd_data.flag ? lve_pkg::set_char(rd_data.set, rd_data.pos) : rd_data.ch;

  assign stat.any_subst = any_subst;
  assign stat.at_last   = (LW'(idx) + LW'(1)) == len;
  assign stat.rd_flag   = rd_data.flag;
  assign stat.rd_wrap   = wrap;

  assign out_char  = cmd.exh_sel ? 8'd0 : cur_char;
  assign last      = cmd.exh_sel | stat.at_last;
  assign exhausted = cmd.exh_sel;

endmodule

// ----- design/lve_ctrl.sv -----
// Controller: state machine that sequences load, odometer advance and emit.
module lve_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  output logic               out_valid,
  input  logic               out_stall,
  input  lve_pkg::lve_stat_t stat,
  output lve_pkg::lve_cmd_t  cmd
);

  lve_pkg::lve_state_t state;
  lve_pkg::lve_state_t state_next;
  logic                in_acc;

  assign in_acc = in_valid && (state == lve_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lve_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lve_pkg::ST_IDLE: begin
        if (in_acc && kind == lve_pkg::KIND_NEXT) begin
          state_next = stat.any_subst ? lve_pkg::ST_ADV_RD : lve_pkg::ST_EXH;
        end
      end
      lve_pkg::ST_ADV_RD: state_next = lve_pkg::ST_ADV_CHK;
      lve_pkg::ST_ADV_CHK: begin
        if (stat.rd_flag && !stat.rd_wrap) begin
          state_next = lve_pkg::ST_EMIT_RD;
        end else if (stat.at_last) begin
          state_next = lve_pkg::ST_EXH;
        end else begin
          state_next = lve_pkg::ST_ADV_RD;
        end
      end
      lve_pkg::ST_EMIT_RD: state_next = lve_pkg::ST_EMIT_OUT;
      lve_pkg::ST_EMIT_OUT: begin
        if (!out_stall) begin
          state_next = stat.at_last ? lve_pkg::ST_IDLE : lve_pkg::ST_EMIT_RD;
        end
      end
      lve_pkg::ST_EXH: begin
        if (!out_stall) begin
          state_next = lve_pkg::ST_IDLE;
        end
      end
      default: state_next = lve_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      lve_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.clear_word = in_acc && kind == lve_pkg::KIND_BEGIN;
        cmd.append     = in_acc && kind == lve_pkg::KIND_APPEND;
        cmd.idx_clear  = 1'b1;
      end
      lve_pkg::ST_ADV_CHK: begin
        cmd.adv_write = 1'b1;
        if (stat.rd_flag && !stat.rd_wrap) begin
          cmd.idx_clear = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      lve_pkg::ST_EMIT_OUT: begin
        out_valid   = 1'b1;
        cmd.idx_inc = !out_stall && !stat.at_last;
      end
      lve_pkg::ST_EXH: begin
        out_valid   = 1'b1;
        cmd.exh_sel = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) rst |=> state == lve_pkg::ST_IDLE)
    else $error("controller not idle after reset");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");
  a_exh_done: assert property (@(posedge clk) disable iff (rst)
      state == lve_pkg::ST_EXH && !out_stall |=> state == lve_pkg::ST_IDLE)
    else $error("exhausted item not followed by idle");
  a_no_subst: assert property (@(posedge clk) disable iff (rst)
      in_acc && kind == lve_pkg::KIND_NEXT && !stat.any_subst |=> state == lve_pkg::ST_EXH)
    else $error("request on plain word did not go exhausted");
`endif

endmodule

// ----- design/leet_variant_enumerator.sv -----
// Top level: leet variant enumerator, controller plus datapath.
// Input channel (in_valid/in_stall, kind, ch): kind BEGIN clears the word, APPEND adds ch
// (zero byte or full word ignored), NEXT advances the substitution odometer; kind 3 is dropped.
// Begin and append give no result item.
// Output channel (out_valid/out_stall, out_char, last, exhausted): a NEXT request gives
// either the whole current variant, one character per item with last on the final one,
// or a single exhausted item (out_char zero, last set) when nothing is transformable or
// the odometer has wrapped back to the original word.
// A NEXT request walks the carry through word positions (ST_ADV_RD, then ST_ADV_CHK, for each),
// then emits characters (ST_EMIT_RD, then ST_EMIT_OUT, for each), because every step reads the
// word memory through its registered read port.
// One item is in work at a time: in_stall is high from the cycle after a NEXT is taken
// until its last result item is taken.
// While out_stall is high the pending result item holds and the block waits.
// Reset (rst, synchronous) empties the word and returns the controller to idle; the word
// memory itself is not cleared.
module leet_variant_enumerator #(
  parameter int MAX_WORD_LEN = lve_pkg::MAX_WORD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last,
  output logic       exhausted
);

  lve_pkg::lve_cmd_t  cmd;
  lve_pkg::lve_stat_t stat;

  lve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lve_dp #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ch        (ch),
    .stat      (stat),
    .out_char  (out_char),
    .last      (last),
    .exhausted (exhausted)
  );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the leet variant enumerator: directed table plus random words, scoreboard checked.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WORD_CAP = lve_pkg::MAX_WORD_LEN_DEF;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       exh;
  } variant_char_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       pin_exh;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [7:0] ch;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       last;
  logic       exhausted;

  leet_variant_enumerator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .ch(ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .last(last),
    .exhausted(exhausted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] leet_tab [6][4] = '{
    '{8'h30, 8'h6f, 8'h4f, 8'h00},
    '{8'h31, 8'h69, 8'h6c, 8'h49},
    '{8'h32, 8'h61, 8'h00, 8'h00},
    '{8'h33, 8'h65, 8'h00, 8'h00},
    '{8'h34, 8'h61, 8'h68, 8'h00},
    '{8'h24, 8'h73, 8'h00, 8'h00}
  };
  int leet_span [6] = '{3, 4, 2, 2, 3, 2};

  stim_row_t script [0:24] = '{
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b1},
    '{KIND_UNUSED,          8'hff, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h00, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'hff, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'hff, 1'b1},
    '{lve_pkg::KIND_BEGIN,  8'ha5, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h5a, 1'b1},
    '{lve_pkg::KIND_APPEND, 8'h32, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h24, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b1},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h31, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_BEGIN,  8'h00, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h30, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h31, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h33, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h34, 1'b0},
    '{lve_pkg::KIND_APPEND, 8'h7f, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{lve_pkg::KIND_NEXT,   8'h00, 1'b0},
    '{KIND_UNUSED,          8'h00, 1'b0}
  };

  logic [7:0] word_chars [WORD_CAP];
  bit         is_leet    [WORD_CAP];
  int         leet_set   [WORD_CAP];
  int         leet_digit [WORD_CAP];
  int         word_len = 0;
  bit         any_leet = 1'b0;

  variant_char_t step_out [$];
  variant_char_t variant_q [$];
  int errors = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  task automatic predict_step(input logic [1:0] k, input logic [7:0] c);
    int i, s, p;
    bit moved;
    variant_char_t item;
    step_out.delete();
    case (k)
      lve_pkg::KIND_BEGIN: begin
        word_len = 0;
        any_leet = 1'b0;
      end
      lve_pkg::KIND_APPEND: begin
        if (c != 8'h00 && word_len < WORD_CAP) begin
          word_chars[word_len] = c;
          is_leet[word_len] = 1'b0;
          leet_set[word_len] = 0;
          leet_digit[word_len] = 0;
          for (s = 0; s < 6; s++) begin
            if (!is_leet[word_len] && leet_tab[s][0] == c) begin
              is_leet[word_len] = 1'b1;
              leet_set[word_len] = s;
              any_leet = 1'b1;
            end
          end
          word_len++;
        end
      end
      lve_pkg::KIND_NEXT: begin
        moved = 1'b0;
        if (any_leet) begin
          for (i = 0; i < word_len && !moved; i++) begin
            if (is_leet[i]) begin
              s = leet_set[i];
              p = leet_digit[i] + 1;
              if (p >= leet_span[s]) begin
                leet_digit[i] = 0;
                word_chars[i] = leet_tab[s][0];
              end else begin
                leet_digit[i] = p;
                word_chars[i] = leet_tab[s][p];
                moved = 1'b1;
              end
            end
          end
        end
        if (!moved) begin
          item = '{chr: 8'h00, last: 1'b1, exh: 1'b1};
          step_out.push_back(item);
        end else begin
          for (i = 0; i < word_len; i++) begin
            item = '{chr: word_chars[i], last: (i == word_len - 1), exh: 1'b0};
            step_out.push_back(item);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [7:0] draw_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return leet_tab[$urandom_range(0, 5)][0];
    if (r == 7) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic pin);
    int gap;
    variant_char_t item;
    gap = in_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    ch = c;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_step(k, c);
    if (pin) begin
      item = '{chr: 8'h00, last: 1'b1, exh: 1'b1};
      variant_q.push_back(item);
    end else begin
      foreach (step_out[i]) variant_q.push_back(step_out[i]);
    end
    @(negedge clk);
  endtask

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    variant_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (variant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, actual out_char=%h last=%b exhausted=%b",
                 $time, out_char, last, exhausted);
      end else begin
        want = variant_q.pop_front();
        if (out_char !== want.chr) begin
          errors++;
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.chr, out_char);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
        end
        if (exhausted !== want.exh) begin
          errors++;
          $display("%0t: exhausted mismatch: expected %b, actual %b", $time, want.exh, exhausted);
        end
      end
    end
  end

  initial begin : stimulus
    int sent, pick, len, reqs;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = lve_pkg::KIND_BEGIN;
    ch = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[r]) send_item(script[r].kind, script[r].ch, script[r].pin_exh);

    sent = 0;
    while (sent < 270) begin
      in_quiet = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
        send_item(lve_pkg::KIND_APPEND, draw_char(), 1'b0);
        sent++;
      end else begin
        if (pick != 1) begin
          send_item(lve_pkg::KIND_BEGIN, 8'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
        repeat (len) begin
          send_item(lve_pkg::KIND_APPEND, draw_char(), 1'b0);
          sent++;
        end
        reqs = $urandom_range(1, 10);
        repeat (reqs) begin
          if ($urandom_range(0, 14) == 0) begin
            send_item(lve_pkg::KIND_APPEND, draw_char(), 1'b0);
            sent++;
          end
          send_item(lve_pkg::KIND_NEXT, 8'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
      end
    end

    in_valid = 1'b0;
    while (variant_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/lve_pkg.sv
design/lve_dp.sv
design/lve_ctrl.sv
design/leet_variant_enumerator.sv
tb/tb_top.sv
